### rtl/core/packet_buffer_free_list_assert.svh
// Assertion macros used by the packet buffer free list RTL.
`ifndef PACKET_BUFFER_FREE_LIST_ASSERT_SVH
`define PACKET_BUFFER_FREE_LIST_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define PBFL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PBFL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define PBFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/core/pbfl_pkg.sv
`default_nettype none

package pbfl_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE  = 2'd2;

    localparam logic [15:0] BUFFER_SIZE_RESET = 16'd2048;

    // Qualified events of one accepted transaction.
    typedef struct packed {
        logic alloc_ok;
        logic alloc_fail;
        logic free_ok;
    } ev_t;

    // Statistics as they stand after the current transaction.
    typedef struct packed {
        logic [8:0]  in_use;
        logic [8:0]  peak;
        logic [31:0] alloc_total;
        logic [31:0] recycle_total;
        logic [31:0] exhaust_total;
    } stats_t;

endpackage

`default_nettype wire

### rtl/core/pbfl_req_if.sv
`default_nettype none

interface pbfl_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] free_index;

    modport source (output valid, output operation, output free_index, input ready);
    modport sink (input valid, input operation, input free_index, output ready);
endinterface

`default_nettype wire

### rtl/core/pbfl_resp_if.sv
`default_nettype none

interface pbfl_resp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [23:0] byte_offset;
    logic [8:0]  slots_in_use;
    logic [8:0]  peak_in_use;
    logic [31:0] alloc_total;
    logic [31:0] recycle_total;
    logic [31:0] exhaust_total;

    modport source (
        output valid, output status, output slot_index, output byte_offset,
        output slots_in_use, output peak_in_use, output alloc_total,
        output recycle_total, output exhaust_total, input ready
    );
    modport sink (
        input valid, input status, input slot_index, input byte_offset,
        input slots_in_use, input peak_in_use, input alloc_total,
        input recycle_total, input exhaust_total, output ready
    );
endinterface

`default_nettype wire

### rtl/core/pbfl_list.sv
`default_nettype none

module pbfl_list
    import pbfl_pkg::*;
#(
    parameter int POOL_DEPTH = 256,
    parameter int LINK_W     = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ev_t               ev,
    input  wire logic [7:0]        free_index,
    output logic      [LINK_W-1:0] head,
    output logic                   empty,
    output logic                   busy
);

    localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_DEPTH);
    localparam logic [LINK_W-1:0] NEXT_RESET = LINK_W'((POOL_DEPTH > 1) ? 1 : POOL_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_DEPTH - 1);

    logic [LINK_W-1:0] link_mem [POOL_DEPTH];

    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] head_next;
    logic [LINK_W-1:0] succ_reg;
    logic [LINK_W-1:0] succ_next;
    logic              use_rd_reg;
    logic              use_rd_next;
    logic [LINK_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clear_cnt_reg;
    logic [ADDR_W-1:0] clear_cnt_next;
    logic              clearing_reg;
    logic              clearing_next;

    logic [LINK_W-1:0] succ_eff;
    logic [ADDR_W+7:0] idx_addr_wide;
    logic [LINK_W+7:0] idx_link_wide;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic              rd_en;

    // The successor of the head is held either in a register or in the
    // read data of the link memory, which was fetched during the last allocate.
    assign succ_eff      = use_rd_reg ? rd_data_reg : succ_reg;
    assign idx_addr_wide = {ADDR_W'(0), free_index};
    assign idx_link_wide = {LINK_W'(0), free_index};

    assign head  = head_reg;
    assign empty = (head_reg == LINK_NONE);
    assign busy  = clearing_reg;

    always_comb
    begin
        head_next   = head_reg;
        succ_next   = succ_reg;
        use_rd_next = use_rd_reg;
        if (ev.alloc_ok)
        begin
            head_next   = succ_eff;
            use_rd_next = 1'b1;
        end
        else if (ev.free_ok)
        begin
            head_next   = idx_link_wide[LINK_W-1:0];
            succ_next   = head_reg;
            use_rd_next = 1'b0;
        end
    end

    always_comb
    begin
        clear_cnt_next = clear_cnt_reg;
        clearing_next  = clearing_reg;
        if (clearing_reg)
        begin
            clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
            if (clear_cnt_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_cnt_reg;
            mem_wdata = (clear_cnt_reg == LAST_ADDR) ? LINK_NONE
                                                     : LINK_W'(clear_cnt_reg) + LINK_W'(1);
        end
        else
        begin
            mem_we    = ev.free_ok;
            mem_waddr = idx_addr_wide[ADDR_W-1:0];
            mem_wdata = head_reg;
        end
    end

    assign rd_en = ev.alloc_ok && (succ_eff != LINK_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            succ_reg      <= NEXT_RESET;
            use_rd_reg    <= 1'b0;
            clear_cnt_reg <= '0;
            clearing_reg  <= 1'b1;
        end
        else
        begin
            head_reg      <= head_next;
            succ_reg      <= succ_next;
            use_rd_reg    <= use_rd_next;
            clear_cnt_reg <= clear_cnt_next;
            clearing_reg  <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= link_mem[succ_eff[ADDR_W-1:0]];
        end
    end

endmodule

`default_nettype wire

### rtl/core/pbfl_stats.sv
`default_nettype none

module pbfl_stats
    import pbfl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire ev_t    ev,
    output stats_t      stats,
    output logic        in_use_zero
);

    logic [31:0] in_use_reg;
    logic [31:0] in_use_next;
    logic [31:0] peak_reg;
    logic [31:0] peak_next;
    logic [31:0] alloc_reg;
    logic [31:0] alloc_next;
    logic [31:0] recycle_reg;
    logic [31:0] recycle_next;
    logic [31:0] exhaust_reg;
    logic [31:0] exhaust_next;
    logic [31:0] in_use_inc;

    // The in-use count saturates; repeated frees of one slot can drive it
    // past the pool depth.
    assign in_use_inc  = (in_use_reg != '1) ? in_use_reg + 32'd1 : in_use_reg;
    assign in_use_zero = (in_use_reg == '0);

    always_comb
    begin
        in_use_next  = in_use_reg;
        peak_next    = peak_reg;
        alloc_next   = alloc_reg;
        recycle_next = recycle_reg;
        exhaust_next = exhaust_reg;
        if (ev.alloc_ok)
        begin
            in_use_next = in_use_inc;
            alloc_next  = alloc_reg + 32'd1;
            if (in_use_inc > peak_reg)
            begin
                peak_next = in_use_inc;
            end
        end
        if (ev.alloc_fail)
        begin
            exhaust_next = exhaust_reg + 32'd1;
        end
        if (ev.free_ok)
        begin
            in_use_next  = in_use_reg - 32'd1;
            recycle_next = recycle_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            peak_reg    <= '0;
            alloc_reg   <= '0;
            recycle_reg <= '0;
            exhaust_reg <= '0;
        end
        else
        begin
            in_use_reg  <= in_use_next;
            peak_reg    <= peak_next;
            alloc_reg   <= alloc_next;
            recycle_reg <= recycle_next;
            exhaust_reg <= exhaust_next;
        end
    end

    assign stats.in_use        = in_use_next[8:0];
    assign stats.peak          = peak_next[8:0];
    assign stats.alloc_total   = alloc_next;
    assign stats.recycle_total = recycle_next;
    assign stats.exhaust_total = exhaust_next;

endmodule

`default_nettype wire

### rtl/core/packet_buffer_free_list.sv
// Packet buffer pool kept as a LIFO linked free list. Each request transaction
// either allocates the slot at the head of the list, returning its index and its
// byte offset (index times buffer_size), or frees a slot back onto the head.
// One request is accepted in every cycle unless sweeping or stalled, and its
// result is registered on the following cycle; the link of the new head is
// fetched from the link memory during each allocate, so back-to-back allocates
// run at full rate. After reset a sweep initializes every link memory entry,
// during which no request is accepted; buffer_size may be written at any time
// the block is idle. Allocating from an empty pool returns the exhausted status,
// and a free of an index beyond the pool or with no slot in use returns the bad
// free status and leaves the state unchanged. Double frees are not detected.
`default_nettype none

`include "packet_buffer_free_list_assert.svh"

module packet_buffer_free_list
    import pbfl_pkg::*;
#(
    parameter int POOL_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    pbfl_req_if.sink         req,
    pbfl_resp_if.source      resp
);

    localparam int LINK_W = $clog2(POOL_DEPTH + 1);

    logic [15:0]       buffer_size_reg;
    logic              resp_valid_reg;
    logic [1:0]        status_reg;
    logic [7:0]        slot_reg;
    logic [23:0]       offset_reg;
    stats_t            stats_reg;

    logic              fire;
    logic              idx_in_range;
    ev_t               ev;
    logic [LINK_W-1:0] head;
    logic              empty;
    logic              busy;
    stats_t            stats;
    logic              in_use_zero;
    logic [1:0]        status_new;
    logic [LINK_W+7:0] slot_wide;
    logic [23:0]       product;

    assign req.ready    = !busy && (!resp_valid_reg || resp.ready);
    assign fire         = req.valid && req.ready;
    assign idx_in_range = (32'(req.free_index) < 32'(POOL_DEPTH));

    assign ev.alloc_ok   = fire && (req.operation == OP_ALLOC) && !empty;
    assign ev.alloc_fail = fire && (req.operation == OP_ALLOC) && empty;
    assign ev.free_ok    = fire && (req.operation == OP_FREE) && idx_in_range && !in_use_zero;

    pbfl_list #(
        .POOL_DEPTH (POOL_DEPTH),
        .LINK_W     (LINK_W)
    ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev         (ev),
        .free_index (req.free_index),
        .head       (head),
        .empty      (empty),
        .busy       (busy)
    );

    pbfl_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev          (ev),
        .stats       (stats),
        .in_use_zero (in_use_zero)
    );

    assign slot_wide = {8'd0, head};
    assign product   = 24'(head) * 24'(buffer_size_reg);

    always_comb
    begin
        if (req.operation == OP_ALLOC)
        begin
            status_new = empty ? STATUS_EXHAUSTED : STATUS_OK;
        end
        else
        begin
            status_new = ev.free_ok ? STATUS_OK : STATUS_BAD_FREE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= BUFFER_SIZE_RESET;
            resp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                buffer_size_reg <= cfg_wdata;
            end
            if (fire)
            begin
                resp_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                resp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_new;
            stats_reg  <= stats;
            if (ev.alloc_ok)
            begin
                slot_reg   <= slot_wide[7:0];
                offset_reg <= product;
            end
            else
            begin
                slot_reg   <= '0;
                offset_reg <= '0;
            end
        end
    end

    assign resp.valid         = resp_valid_reg;
    assign resp.status        = status_reg;
    assign resp.slot_index    = slot_reg;
    assign resp.byte_offset   = offset_reg;
    assign resp.slots_in_use  = stats_reg.in_use;
    assign resp.peak_in_use   = stats_reg.peak;
    assign resp.alloc_total   = stats_reg.alloc_total;
    assign resp.recycle_total = stats_reg.recycle_total;
    assign resp.exhaust_total = stats_reg.exhaust_total;

    `PBFL_ASSERT_NEXT(a_alloc_ok_status, clk, rst_n, ev.alloc_ok, resp.valid && (resp.status == STATUS_OK), "granted allocate did not report ok")

    `PBFL_ASSERT_NEXT(a_free_idle_bad, clk, rst_n, fire && (req.operation == OP_FREE) && in_use_zero, resp.valid && (resp.status == STATUS_BAD_FREE), "free with nothing in use was not rejected")

    `PBFL_ASSERT_NOW(a_fail_no_slot, clk, rst_n, resp.valid && (resp.status != STATUS_OK), (resp.slot_index == 8'd0) && (resp.byte_offset == 24'd0), "failed transaction carries a slot")

endmodule

`default_nettype wire

### sim/tb_packet_buffer_free_list.sv
`timescale 1ns / 1ps

module tb_packet_buffer_free_list;
    import pbfl_pkg::*;

    localparam int POOL_SLOTS = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [23:0] offset;
        logic [8:0]  in_use;
        logic [8:0]  peak;
        logic [31:0] allocs;
        logic [31:0] recycles;
        logic [31:0] exhausts;
    } pool_result_t;

    typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic         op;
        logic [15:0]  arg;
        bit           typed;
        pool_result_t want;
    } table_row_t;

    localparam pool_result_t NO_RESULT = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    pbfl_req_if req_bus ();
    pbfl_resp_if resp_bus ();

    packet_buffer_free_list #(
        .POOL_DEPTH(POOL_SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(req_bus),
        .resp(resp_bus)
    );

    always #5 clk = ~clk;

    // Shadow copy of the pool state, advanced once per accepted request.
    logic [8:0]  link_mem [POOL_SLOTS];
    logic [8:0]  pool_head;
    logic [31:0] in_use_cnt;
    logic [31:0] peak_cnt;
    logic [31:0] alloc_cnt;
    logic [31:0] recycle_cnt;
    logic [31:0] exhaust_cnt;
    logic [15:0] buffer_size;
    logic [7:0]  held_slots[$];

    pool_result_t awaited_results[$];
    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 30;
    int recv_idle_pct = 54;

    table_row_t directed_rows [16] = '{
        '{ROW_REQUEST, OP_FREE, 16'd0, 1'b1,
          '{STATUS_BAD_FREE, 8'd0, 24'd0, 9'd0, 9'd0, 32'd0, 32'd0, 32'd0}},
        '{ROW_REQUEST, OP_FREE, 16'd255, 1'b1,
          '{STATUS_BAD_FREE, 8'd0, 24'd0, 9'd0, 9'd0, 32'd0, 32'd0, 32'd0}},
        '{ROW_REQUEST, OP_ALLOC, 16'd0, 1'b1,
          '{STATUS_OK, 8'd0, 24'd0, 9'd1, 9'd1, 32'd1, 32'd0, 32'd0}},
        '{ROW_REQUEST, OP_ALLOC, 16'd0, 1'b1,
          '{STATUS_OK, 8'd1, 24'd2048, 9'd2, 9'd2, 32'd2, 32'd0, 32'd0}},
        '{ROW_REQUEST, OP_FREE, 16'd1, 1'b1,
          '{STATUS_OK, 8'd0, 24'd0, 9'd1, 9'd2, 32'd2, 32'd1, 32'd0}},
        '{ROW_REQUEST, OP_ALLOC, 16'd0, 1'b1,
          '{STATUS_OK, 8'd1, 24'd2048, 9'd2, 9'd2, 32'd3, 32'd1, 32'd0}},
        '{ROW_CONFIG, OP_ALLOC, 16'd65535, 1'b0, NO_RESULT},
        '{ROW_REQUEST, OP_ALLOC, 16'd0, 1'b0, NO_RESULT},
        '{ROW_CONFIG, OP_ALLOC, 16'd0, 1'b0, NO_RESULT},
        '{ROW_REQUEST, OP_ALLOC, 16'd0, 1'b0, NO_RESULT},
        '{ROW_CONFIG, OP_ALLOC, 16'd1, 1'b0, NO_RESULT},
        '{ROW_REQUEST, OP_FREE, 16'd2, 1'b0, NO_RESULT},
        '{ROW_REQUEST, OP_FREE, 16'd0, 1'b0, NO_RESULT},
        '{ROW_REQUEST, OP_ALLOC, 16'd0, 1'b0, NO_RESULT},
        '{ROW_REQUEST, OP_ALLOC, 16'd0, 1'b0, NO_RESULT},
        '{ROW_REQUEST, OP_FREE, 16'd3, 1'b0, NO_RESULT}
    };

    function automatic pool_result_t pool_step(input logic op, input logic [7:0] idx);
        pool_result_t r;
        logic [31:0] product;
        int pos;
        r = '0;
        pos = -1;
        if (op == OP_ALLOC) begin
            if (pool_head >= POOL_SLOTS) begin
                r.status = STATUS_EXHAUSTED;
                exhaust_cnt++;
            end
            else begin
                r.slot = pool_head[7:0];
                product = 32'(pool_head) * 32'(buffer_size);
                r.offset = product[23:0];
                held_slots.push_back(pool_head[7:0]);
                pool_head = link_mem[pool_head[7:0]];
                alloc_cnt++;
                if (in_use_cnt != 32'hFFFF_FFFF)
                begin
                    in_use_cnt++;
                end
                if (in_use_cnt > peak_cnt)
                begin
                    peak_cnt = in_use_cnt;
                end
            end
        end
        else begin
            if (32'(idx) >= POOL_SLOTS || in_use_cnt == 0) begin
                r.status = STATUS_BAD_FREE;
            end
            else begin
                link_mem[idx] = pool_head;
                pool_head = {1'b0, idx};
                in_use_cnt--;
                recycle_cnt++;
                foreach (held_slots[k])
                begin
                    if (pos < 0 && held_slots[k] == idx)
                    begin
                        pos = k;
                    end
                end
                if (pos >= 0)
                begin
                    held_slots.delete(pos);
                end
            end
        end
        r.in_use = in_use_cnt[8:0];
        r.peak = peak_cnt[8:0];
        r.allocs = alloc_cnt;
        r.recycles = recycle_cnt;
        r.exhausts = exhaust_cnt;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_request(input logic op, input logic [7:0] idx, input bit typed,
                                input pool_result_t want);
        pool_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge clk);
        req_bus.valid <= 1'b1;
        req_bus.operation <= op;
        req_bus.free_index <= idx;
        do
        begin
            @(posedge clk);
        end
        while (req_bus.ready !== 1'b1);
        predicted = pool_step(op, idx);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_buffer_size(input logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        buffer_size = value;
    endtask

    // Each phase first drains the pool to exhaustion, then runs bursts that lean
    // toward allocating, toward freeing held slots, or mix the two.
    task automatic run_phase(input int items, input bit allow_double_free);
        int sent;
        int burst_len;
        int alloc_pct;
        int pick;
        sent = 0;
        while (pool_head < POOL_SLOTS)
        begin
            send_request(OP_ALLOC, 8'd0, 1'b0, NO_RESULT);
            sent++;
        end
        repeat ($urandom_range(1, 3))
        begin
            send_request(OP_ALLOC, 8'd0, 1'b0, NO_RESULT);
            sent++;
        end
        while (sent < items)
        begin
            case ($urandom_range(2))
                0: alloc_pct = 85;
                1: alloc_pct = 15;
                default: alloc_pct = 50;
            endcase
            burst_len = $urandom_range(1, 60);
            repeat (burst_len)
            begin
                pick = $urandom_range(99);
                if (allow_double_free && sent >= items - 60 && pick < 8)
                begin
                    send_request(OP_FREE, 8'($urandom_range(255)), 1'b0, NO_RESULT);
                end
                else if (pick < alloc_pct)
                begin
                    send_request(OP_ALLOC, 8'($urandom_range(255)), 1'b0, NO_RESULT);
                end
                else if (held_slots.size() > 0)
                begin
                    send_request(OP_FREE, held_slots[$urandom_range(held_slots.size() - 1)],
                                 1'b0, NO_RESULT);
                end
                else
                begin
                    send_request(OP_FREE, 8'($urandom_range(255)), 1'b0, NO_RESULT);
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        resp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            resp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        pool_result_t want;
        if (rst_n === 1'b1 && resp_bus.valid === 1'b1 && resp_bus.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result transaction with no request outstanding", $time);
            end
            else begin
                want = awaited_results.pop_front();
                compare_field("status", 32'(want.status), 32'(resp_bus.status));
                compare_field("slot_index", 32'(want.slot), 32'(resp_bus.slot_index));
                compare_field("byte_offset", 32'(want.offset), 32'(resp_bus.byte_offset));
                compare_field("slots_in_use", 32'(want.in_use), 32'(resp_bus.slots_in_use));
                compare_field("peak_in_use", 32'(want.peak), 32'(resp_bus.peak_in_use));
                compare_field("alloc_total", want.allocs, resp_bus.alloc_total);
                compare_field("recycle_total", want.recycles, resp_bus.recycle_total);
                compare_field("exhaust_total", want.exhausts, resp_bus.exhaust_total);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("packet_buffer_free_list: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 16'd0;
        req_bus.valid = 1'b0;
        req_bus.operation = OP_ALLOC;
        req_bus.free_index = 8'd0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            link_mem[i] = 9'(i + 1);
        end
        pool_head = 9'd0;
        in_use_cnt = '0;
        peak_cnt = '0;
        alloc_cnt = '0;
        recycle_cnt = '0;
        exhaust_cnt = '0;
        buffer_size = BUFFER_SIZE_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
            begin
                write_buffer_size(directed_rows[i].arg);
            end
            else begin
                send_request(directed_rows[i].op, directed_rows[i].arg[7:0],
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        write_buffer_size(16'hFFFF);
        run_phase(300, 1'b0);

        send_idle_pct = 54;
        recv_idle_pct = 30;
        write_buffer_size(16'd1);
        run_phase(300, 1'b0);

        // Double frees corrupt the list for good, so they only appear at the very end.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_buffer_size(16'($urandom_range(2, 65534)));
        run_phase(300, 1'b1);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("packet_buffer_free_list: match");
        end
        else begin
            $display("packet_buffer_free_list: mismatch");
        end
        $finish;
    end

endmodule
